>>> hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int unsigned IdxW = 16;

  localparam logic [2:0] CMD_WRITE_REG  = 3'd0;
  localparam logic [2:0] CMD_READ_REG   = 3'd1;
  localparam logic [2:0] CMD_PLAIN_READ = 3'd2;
  localparam logic [2:0] CMD_START_SENT = 3'd3;
  localparam logic [2:0] CMD_ADDR_SENT  = 3'd4;
  localparam logic [2:0] CMD_BYTE_DONE  = 3'd5;
  localparam logic [2:0] CMD_BYTE_RECV  = 3'd6;
  localparam logic [2:0] CMD_BUS_ERROR  = 3'd7;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_START_RD = 3'd2;
  localparam logic [2:0] ST_ADDRESS  = 3'd3;
  localparam logic [2:0] ST_READING  = 3'd4;

  localparam logic [1:0] ADDR_NONE  = 2'd0;
  localparam logic [1:0] ADDR_WRITE = 2'd1;
  localparam logic [1:0] ADDR_READ  = 2'd2;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_OK   = 2'd1;
  localparam logic [1:0] FIN_ERR  = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_START    = 5'b00010,
    PH_START_RD = 5'b00100,
    PH_ADDRESS  = 5'b01000,
    PH_READING  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [7:0]      slave_address;
    logic [7:0]      register_address;
    logic [IdxW-1:0] byte_count;
    logic [7:0]      transmit_data;
    logic [7:0]      receive_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            start_req;
    logic [1:0]      address_req;
    logic [7:0]      address_byte;
    logic            transmit_req;
    logic [7:0]      transmit_byte;
    logic [1:0]      ack_ctrl;
    logic            stop_req;
    logic            store_valid;
    logic [7:0]      store_byte;
    logic [IdxW-1:0] buffer_index;
    logic [1:0]      finish;
  } out_item_t;

  typedef struct packed {
    phase_t          phase;
    logic [7:0]      target_address;
    logic [7:0]      reg_address;
    logic [IdxW-1:0] length;
    logic [IdxW-1:0] position;
    logic            is_read;
  } seq_state_t;

endpackage

>>> hw/rtl/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps
// pipeline: an input beat is held in the input reg, then its step result in the result reg
// (input reg, result reg); the step logic updates the state only as a beat advances
// throughput: one beat per cycle unless out_stall holds the result reg
// in_stall rises only when the input reg is full and the result reg is held by out_stall
// reset: synchronous active-low rst_n empties both regs and returns the phase to idle
// with all addresses, length and position cleared; no clearing pass is needed

module i2c_master_transfer_sequencer import i2cms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  seq_state_t st_r, st_nxt;
  out_item_t  step_res;
  logic       in_take;
  logic       s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  i2cms_step u_step (
    .item   (s1_data_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_IDLE, default: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result reg not loaded after step");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without back pressure");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.finish != FIN_NONE) |-> (out_data_r.status == ST_IDLE))
    else $error("finish reported outside idle");

  a_store_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.store_valid) |->
      (out_data_r.status == ST_READING || out_data_r.status == ST_IDLE))
    else $error("store outside read phase");

  a_idle_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && step_res.finish != FIN_NONE) |=> (st_r.phase == PH_IDLE))
    else $error("state not idle after finish");

endmodule

>>> hw/rtl/i2cms_step.sv
`timescale 1ns / 1ps

module i2cms_step import i2cms_pkg::*; (
  input  in_item_t   item,
  input  seq_state_t st,
  output seq_state_t st_nxt,
  output out_item_t  res
);

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_START:    code = ST_START;
      PH_START_RD: code = ST_START_RD;
      PH_ADDRESS:  code = ST_ADDRESS;
      PH_READING:  code = ST_READING;
      default:     code = ST_IDLE;
    endcase
    return code;
  endfunction

  logic [IdxW-1:0] pos_inc;
  logic [IdxW-1:0] len_dec;
  logic [IdxW-1:0] pos_after;

  assign pos_inc = st.position + 1'b1;
  assign len_dec = st.length - 1'b1;

  always_comb begin
    st_nxt    = st;
    res       = '0;
    pos_after = st.position;
    unique case (item.cmd)
      CMD_WRITE_REG, CMD_READ_REG, CMD_PLAIN_READ: begin
        st_nxt.phase          = (item.cmd == CMD_PLAIN_READ) ? PH_START_RD : PH_START;
        st_nxt.target_address = item.slave_address;
        st_nxt.reg_address    = item.register_address;
        st_nxt.length         = item.byte_count;
        st_nxt.position       = '0;
        st_nxt.is_read        = (item.cmd != CMD_WRITE_REG);
        res.start_req         = 1'b1;
      end
      CMD_START_SENT: begin
        if (st.phase == PH_START) begin
          res.address_req  = ADDR_WRITE;
          res.address_byte = st.target_address;
          st_nxt.phase     = PH_ADDRESS;
        end else if (st.phase == PH_START_RD) begin
          res.ack_ctrl     = ACK_ENABLE;
          res.address_req  = ADDR_READ;
          res.address_byte = st.target_address;
          st_nxt.phase     = PH_READING;
        end
      end
      CMD_ADDR_SENT: begin
        if (st.phase == PH_ADDRESS) begin
          res.transmit_req  = 1'b1;
          res.transmit_byte = st.reg_address;
        end else if (st.phase == PH_READING && st.length == IdxW'(1)) begin
          res.ack_ctrl = ACK_DISABLE;
        end
      end
      CMD_BYTE_DONE: begin
        if (st.phase == PH_ADDRESS) begin
          if (st.is_read) begin
            res.start_req = 1'b1;
            st_nxt.phase  = PH_START_RD;
          end else begin
            if (st.position < st.length) begin
              res.transmit_req  = 1'b1;
              res.transmit_byte = item.transmit_data;
              res.buffer_index  = st.position;
              pos_after         = pos_inc;
            end
            st_nxt.position = pos_after;
            if (pos_after == st.length) begin
              res.stop_req = 1'b1;
              res.finish   = FIN_OK;
              st_nxt.phase = PH_IDLE;
            end
          end
        end
      end
      CMD_BYTE_RECV: begin
        if (st.phase == PH_READING) begin
          res.store_valid  = 1'b1;
          res.store_byte   = item.receive_data;
          res.buffer_index = st.position;
          st_nxt.position  = pos_inc;
          if (st.length != '0 && pos_inc == len_dec) begin
            res.ack_ctrl = ACK_DISABLE;
          end
          if (pos_inc == st.length) begin
            res.stop_req = 1'b1;
            res.finish   = FIN_OK;
            st_nxt.phase = PH_IDLE;
          end
        end
      end
      CMD_BUS_ERROR: begin
        res.finish   = FIN_ERR;
        st_nxt.phase = PH_IDLE;
      end
    endcase
    res.status = phase_code(st_nxt.phase);
  end

endmodule
